// ----- hw/rtl/dpsqrt_pkg.sv -----
// Shared types and constants for the binary64 square root pipeline.
// No dependencies.
package dpsqrt_pkg;

  localparam int unsigned RootBits = 54;
  localparam int unsigned RemBits  = 57;

  localparam logic [1:0] RmNearest = 2'd0;
  localparam logic [1:0] RmZero    = 2'd1;
  localparam logic [1:0] RmUp      = 2'd2;
  localparam logic [1:0] RmDown    = 2'd3;

  localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;

  // Per-request sideband carried through the cell chain
  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic        special_inv;
    logic [10:0] exp_field;
    logic [1:0]  rmode;
  } side_t;

  // Recurrence state handed from cell to cell
  typedef struct packed {
    logic [RemBits-1:0]  rem;
    logic [RootBits:0]   s;
    logic [RootBits-1:0] q;
  } rec_t;

endpackage

// ----- hw/rtl/double_precision_square_root.sv -----
// Binary64 square root as a chain of 54 restoring cells.
// Pipeline: the decode register, 54 cell registers and the rounded output register.
// Throughput: one request per cycle; the whole chain holds while out stalls.
// Reset: rst synchronously clears all valid bits and sets rounding_mode to
// nearest even. Depends on dpsqrt_pkg, dpsqrt_unpack, dpsqrt_cell.
module double_precision_square_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_bits,
  output logic        invalid_flag,
  output logic        inexact_flag
);

  localparam int unsigned N = dpsqrt_pkg::RootBits;

  logic [1:0]        rounding_mode;
  logic              en;
  logic              v   [N+1];
  dpsqrt_pkg::rec_t  rec [N+1];
  dpsqrt_pkg::side_t sd  [N+1];
  logic [54:0]       q_r;
  logic [63:0]       res_next;
  logic              inx_next;

  // Hold the chain while the output register is full and stalled
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode <= dpsqrt_pkg::RmNearest;
    end else if (cfg_we) begin
      rounding_mode <= cfg_wdata;
    end
  end

  dpsqrt_unpack u_unpack (
    .clk, .rst, .en, .in_valid, .operand_bits, .rmode(rounding_mode),
    .out_valid(v[0]), .out_rec(rec[0]), .out_side(sd[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    dpsqrt_cell #(.Step(g)) u_cell (
      .clk, .rst, .en,
      .in_valid(v[g]), .in_rec(rec[g]), .in_side(sd[g]),
      .out_valid(v[g+1]), .out_rec(rec[g+1]), .out_side(sd[g+1])
    );
  end

  // Round and pack; a carry out of the root bumps the exponent once more
  always_comb begin
    q_r      = {1'b0, rec[N].q};
    inx_next = 1'b0;
    if (sd[N].special) begin
      res_next = sd[N].special_bits;
    end else begin
      if (rec[N].rem != '0) begin
        inx_next = 1'b1;
        unique case (sd[N].rmode)
          dpsqrt_pkg::RmNearest: q_r = q_r + {54'b0, q_r[0]};
          dpsqrt_pkg::RmUp:      q_r = q_r + 55'd2;
          dpsqrt_pkg::RmZero,
          dpsqrt_pkg::RmDown:    q_r = q_r;
          default:               q_r = q_r;
        endcase
      end
      res_next = {1'b0, sd[N].exp_field, 52'b0} + {10'b0, q_r[54:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_bits  <= res_next;
      invalid_flag <= sd[N].special & sd[N].special_inv;
      inexact_flag <= inx_next;
    end
  end

endmodule

// ----- hw/rtl/dpsqrt_cell.sv -----
// One restoring square root step with its pipeline register.
// Depends on dpsqrt_pkg.
module dpsqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  dpsqrt_pkg::rec_t   in_rec,
  input  dpsqrt_pkg::side_t  in_side,
  output logic               out_valid,
  output dpsqrt_pkg::rec_t   out_rec,
  output dpsqrt_pkg::side_t  out_side
);

  localparam int unsigned Rb = dpsqrt_pkg::RootBits - 1 - Step;

  logic [dpsqrt_pkg::RootBits:0]  r;
  logic [dpsqrt_pkg::RootBits:0]  t;
  logic [dpsqrt_pkg::RemBits-1:0] t_ext;
  logic                           take;
  dpsqrt_pkg::rec_t               rec_next;

  // Trial subtract, keep on success, shift remainder
  always_comb begin
    r        = '0;
    r[Rb]    = 1'b1;
    t        = in_rec.s + r;
    t_ext    = {{(dpsqrt_pkg::RemBits - dpsqrt_pkg::RootBits - 1){1'b0}}, t};
    take     = (t_ext <= in_rec.rem);
    rec_next = in_rec;
    if (take) begin
      rec_next.s      = t + r;
      rec_next.rem    = in_rec.rem - t_ext;
      rec_next.q[Rb]  = 1'b1;
    end
    rec_next.rem = {rec_next.rem[dpsqrt_pkg::RemBits-2:0], 1'b0};
  end

  // Advance when the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec  <= rec_next;
      out_side <= in_side;
    end
  end

endmodule

// ----- hw/rtl/dpsqrt_unpack.sv -----
// Operand decode, special cases and normalization into the first register.
// Depends on dpsqrt_pkg.
module dpsqrt_unpack (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        operand_bits,
  input  logic [1:0]         rmode,
  output logic               out_valid,
  output dpsqrt_pkg::rec_t   out_rec,
  output dpsqrt_pkg::side_t  out_side
);

  logic [10:0]       fld;
  logic [51:0]       frac;
  logic [5:0]        lz;
  logic [52:0]       m;
  logic [12:0]       e;
  logic [10:0]       eres;
  logic [54:0]       mm;
  dpsqrt_pkg::side_t side;
  dpsqrt_pkg::rec_t  rec;

  assign fld  = operand_bits[62:52];
  assign frac = operand_bits[51:0];

  // Leading zero count of the fraction for subnormals
  always_comb begin
    lz = 6'd52;
    for (int i = 0; i < 52; i++) begin
      if (frac[i]) lz = 6'(51 - i);
    end
  end

  // Classify, normalize, make exponent even
  always_comb begin
    side              = '0;
    side.rmode        = rmode;
    side.special_bits = operand_bits;
    if (fld == 11'h7FF) begin
      side.special = 1'b1;
      if (frac == '0) begin
        if (operand_bits[63]) begin
          side.special_bits = dpsqrt_pkg::DefaultNan;
          side.special_inv  = 1'b1;
        end
      end else begin
        side.special_bits = operand_bits | dpsqrt_pkg::QuietBit;
        side.special_inv  = ~operand_bits[51];
      end
    end else if (operand_bits[62:0] == '0) begin
      side.special = 1'b1;
    end else if (operand_bits[63]) begin
      side.special      = 1'b1;
      side.special_bits = dpsqrt_pkg::DefaultNan;
      side.special_inv  = 1'b1;
    end
    // e biased by +1100 to stay positive
    if (fld == '0) begin
      m = {1'b0, frac} << (lz + 6'd1);
      e = 13'd1100 - 13'd1022 - 13'(lz) - 13'd1;
    end else begin
      m = {1'b1, frac};
      e = 13'(fld) - 13'd1023 + 13'd1100;
    end
    mm = {2'b0, m};
    if (e[0]) begin
      mm = {1'b0, m, 1'b0};
      e  = e - 13'd1;
    end
    // e/2 + 1022 with bias removed: (e-1100)/2+1022 = e/2 + 472
    eres           = 11'((e >> 1) + 13'd472);
    side.exp_field = eres;
    rec.rem = {1'b0, mm, 1'b0};
    rec.s   = '0;
    rec.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec  <= rec;
      out_side <= side;
    end
  end

endmodule

// ----- sim/sqrt_checker.sv -----
// Checker for the binary64 square root: watches the request and result channels,
// predicts each root from the operand and rounding mode, and compares.
// Depends on dpsqrt_pkg.
`timescale 1ns / 1ps
module sqrt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] operand_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_bits,
  input  logic        invalid_flag,
  input  logic        inexact_flag,
  output int          fail_count,
  output int          pending_roots
);

  typedef struct packed {
    logic [63:0] bits;
    logic        inv;
    logic        inx;
  } root_t;

  logic [1:0] round_mode;
  root_t      root_queue[$];

  assign pending_roots = root_queue.size();

  // Compute the correctly rounded root of one operand
  function automatic root_t predict_root(logic [63:0] x, logic [1:0] rm);
    root_t       r;
    logic [63:0] m, ix, q, s, step, t;
    int          e;
    r = '0;
    if (x[62:52] == 11'h7FF) begin
      if (x[51:0] == 0) begin
        if (x[63]) begin
          r.bits = dpsqrt_pkg::DefaultNan;
          r.inv = 1'b1;
        end else begin
          r.bits = x;
        end
      end else begin
        r.inv = ~x[51];
        r.bits = x | dpsqrt_pkg::QuietBit;
      end
    end else if (x[62:0] == 0) begin
      r.bits = x;
    end else if (x[63]) begin
      r.bits = dpsqrt_pkg::DefaultNan;
      r.inv = 1'b1;
    end else begin
      if (x[62:52] == 0) begin
        m = {12'd0, x[51:0]};
        e = -1022;
        while (m[52] == 1'b0) begin
          m = m << 1;
          e = e - 1;
        end
      end else begin
        m = {11'd0, 1'b1, x[51:0]};
        e = int'(x[62:52]) - 1023;
      end
      if (e % 2 != 0) begin
        m = m << 1;
        e = e - 1;
      end
      ix = m << 1;
      q = 0;
      s = 0;
      step = 64'd1 << 53;
      for (int j = 0; j < 54; j++) begin
        t = s + step;
        if (t <= ix) begin
          s = t + step;
          ix = ix - t;
          q = q + step;
        end
        ix = ix << 1;
        step = step >> 1;
      end
      if (ix != 0) begin
        r.inx = 1'b1;
        if (rm == dpsqrt_pkg::RmNearest) q = q + {63'd0, q[0]};
        else if (rm == dpsqrt_pkg::RmUp) q = q + 64'd2;
      end
      r.bits = (64'(e / 2 + 1022) << 52) + (q >> 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // Track mode, queue predictions, compare results
  always @(posedge clk) begin
    root_t want;
    if (rst) begin
      round_mode <= dpsqrt_pkg::RmNearest;
      root_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) round_mode <= cfg_wdata;
      if (in_valid && !in_stall) root_queue.push_back(predict_root(operand_bits, round_mode));
      if (out_valid && !out_stall) begin
        if (root_queue.size() == 0) begin
          report_mismatch("unexpected result", result_bits, 64'd0);
        end else begin
          want = root_queue.pop_front();
          if (result_bits !== want.bits) report_mismatch("root", result_bits, want.bits);
          if (invalid_flag !== want.inv) report_mismatch("invalid", 64'(invalid_flag), 64'(want.inv));
          if (inexact_flag !== want.inx) report_mismatch("inexact", 64'(inexact_flag), 64'(want.inx));
        end
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the square root testbench: clock, reset, request and mode stimulus,
// random stalls and the verdict. Depends on dpsqrt_pkg, sqrt_checker and the block.
`timescale 1ns / 1ps
module testbench;

  localparam int Latency = 56;
  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = dpsqrt_pkg::RmNearest;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] operand_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_bits;
  logic        invalid_flag, inexact_flag;
  int          fail_count, pending_roots;
  int          cycle_count = 0;
  bit          calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  double_precision_square_root dut (.*);
  sqrt_checker checker_i (.*);

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 26);
  end

  // Enforce the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'h000;
      2: v[62:0] = 63'd0;
      3: v[63] = 1'b1;
      default: v[63] = 1'b0;
    endcase
    return v;
  endfunction

  // Send one request, holding it while stalled; idle cycles drop valid
  task automatic send_operand(logic [63:0] v);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_bits <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain all roots, then let the chain settle
  task automatic drain_roots();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_roots != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] rm);
    cfg_we <= 1'b1;
    cfg_wdata <= rm;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [63:0] directed[$] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
    64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h7FF0_0000_0000_0001,
    64'hFFF4_5555_AAAA_0000, 64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
    64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000,
    64'h4010_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF, 64'h4008_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555
  };

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed operands under every rounding mode
    for (int m = 0; m < 4; m++) begin
      write_mode(2'(m));
      foreach (directed[i]) send_operand(directed[i]);
      drain_roots();
    end
    // Random phases, each under a randomly chosen mode, with a calm third phase
    for (int p = 0; p < 4; p++) begin
      write_mode(2'($urandom_range(3)));
      calm = (p == 2);
      for (int i = 0; i < 200; i++) begin
        send_operand(random_operand());
        if (i == 100) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_roots != 0) @(posedge clk);
        end
      end
      calm = 1'b0;
      drain_roots();
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dpsqrt_pkg.sv
hw/rtl/dpsqrt_cell.sv
hw/rtl/dpsqrt_unpack.sv
hw/rtl/double_precision_square_root.sv
sim/sqrt_checker.sv
sim/testbench.sv
